### hdl/qpht_pkg.sv
package qpht_pkg;

	// Widths fixed by the item and register formats
	localparam int TS_BITS     = 11;
	localparam int SLOT_BITS   = 10;
	localparam int KEY_IN_BITS = 32;

	// Digits of the home-slot remainder retired per cycle
	localparam int DIV_STEP = 4;

	// Action codes
	typedef enum logic {
		ACT_FIND   = 1'b0,
		ACT_INSERT = 1'b1
	} action_t;

	// Status from the probe engine to the front end
	typedef struct packed {
		logic ready;
	} back_status_t;

endpackage

### hdl/qpht_fifo.sv
module qpht_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = mem_q[rd_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_q <= ~wr_q;
			end
			if (pop && !empty) begin
				rd_q <= ~rd_q;
			end
			unique case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hdl/qpht_front.sv
module qpht_front #(
	parameter int CAPACITY = 1024,
	parameter int KEY_BITS = 32,
	parameter int AW       = 10,
	parameter int NW       = 11,
	parameter int EW       = 43
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  qpht_pkg::back_status_t        status,
	input  logic [NW-1:0]                 n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [qpht_pkg::KEY_IN_BITS-1:0] key,
	output logic                          push,
	output logic [EW-1:0]                 push_data,
	input  logic                          full
);

	localparam int KE = (KEY_BITS < qpht_pkg::KEY_IN_BITS) ? KEY_BITS : qpht_pkg::KEY_IN_BITS;
	localparam int ND = (KE + qpht_pkg::DIV_STEP - 1) / qpht_pkg::DIV_STEP;
	localparam int KP = ND * qpht_pkg::DIV_STEP;
	localparam int CW = $clog2(ND + 1);

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

	fstate_t             state_q;
	logic                act_q;
	logic [KEY_BITS-1:0] key_q;
	logic [KP-1:0]       sh_q;
	logic [NW-1:0]       rem_q;
	logic [CW-1:0]       cnt_q;
	logic [NW-1:0]       rem_nxt;
	logic [NW:0]         t;
	logic [KE-1:0]       key_eff;

	assign in_stall  = !(state_q == F_IDLE && status.ready);
	assign push      = (state_q == F_PUSH);
	assign push_data = {act_q, key_q, rem_q[AW-1:0]};
	assign key_eff   = KE'(key);

	// Retire several remainder digits per cycle
	always_comb begin
		t = {1'b0, rem_q};
		for (int i = 0; i < qpht_pkg::DIV_STEP; i++) begin
			t = {t[NW-1:0], sh_q[KP-1-i]};
			if (t >= {1'b0, n}) begin
				t = t - {1'b0, n};
			end
		end
		rem_nxt = t[NW-1:0];
	end

	// Accept, divide, hand over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			act_q   <= 1'b0;
			key_q   <= '0;
			sh_q    <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid && !in_stall) begin
						act_q   <= action;
						key_q   <= KEY_BITS'(key_eff);
						sh_q    <= KP'(key_eff);
						rem_q   <= '0;
						cnt_q   <= CW'(ND);
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					rem_q <= rem_nxt;
					sh_q  <= sh_q << qpht_pkg::DIV_STEP;
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

### hdl/qpht_back.sv
module qpht_back #(
	parameter int CAPACITY = 1024,
	parameter int KEY_BITS = 32,
	parameter int AW       = 10,
	parameter int NW       = 11,
	parameter int EW       = 43
) (
	input  logic                           clk,
	input  logic                           arst_n,
	output qpht_pkg::back_status_t         status,
	input  logic [NW-1:0]                  n,
	input  logic                           empty,
	input  logic [EW-1:0]                  pop_data,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [qpht_pkg::SLOT_BITS-1:0] slot,
	output logic                           present,
	output logic                           stored,
	output logic                           table_full
);

	typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_READ, B_CHECK} bstate_t;

	logic                vmem [CAPACITY];
	logic [KEY_BITS-1:0] kmem [CAPACITY];

	bstate_t             state_q;
	logic [AW-1:0]       clr_q;
	logic [AW-1:0]       pos_q;
	logic [NW-1:0]       inc_q;
	logic [NW-1:0]       probe_q;
	logic                act_q;
	logic [KEY_BITS-1:0] key_q;
	logic                rd_valid_q;
	logic [KEY_BITS-1:0] rd_key_q;
	logic                out_valid_q;
	logic [qpht_pkg::SLOT_BITS-1:0] slot_q;
	logic                present_q;
	logic                stored_q;
	logic                full_q;

	logic                out_free;
	logic                is_match;
	logic                done;
	logic                last;
	logic                do_ins;
	logic                we;
	logic [AW-1:0]       waddr;
	logic [NW:0]         inc_sum;
	logic [NW-1:0]       inc_nxt;
	logic [NW:0]         pos_sum;
	logic [NW-1:0]       pos_nxt;

	assign status.ready = (state_q != B_CLEAR);
	assign pop          = (state_q == B_IDLE) && !empty;
	assign out_valid    = out_valid_q;
	assign slot         = slot_q;
	assign present      = present_q;
	assign stored       = stored_q;
	assign table_full   = full_q;

	assign out_free = !out_valid_q || !out_stall;
	assign is_match = rd_valid_q && (rd_key_q == key_q);
	assign last     = (probe_q + NW'(1)) == n;
	assign done     = !rd_valid_q || is_match || last;
	assign do_ins   = (state_q == B_CHECK) && out_free && !rd_valid_q
		&& (act_q == qpht_pkg::ACT_INSERT);

	// Step the increment by two and the probe position by the increment, both kept below n
	always_comb begin
		inc_sum = {1'b0, inc_q} + (NW + 1)'(2);
		inc_nxt = (inc_sum >= {1'b0, n}) ? NW'(inc_sum - {1'b0, n}) : NW'(inc_sum);
		pos_sum = (NW + 1)'(pos_q) + (NW + 1)'(inc_q);
		pos_nxt = (pos_sum >= {1'b0, n}) ? NW'(pos_sum - {1'b0, n}) : NW'(pos_sum);
	end

	// Select write port
	always_comb begin
		we    = (state_q == B_CLEAR) || do_ins;
		waddr = (state_q == B_CLEAR) ? clr_q : pos_q;
	end

	// Valid memory
	always_ff @(posedge clk) begin
		if (we) begin
			vmem[waddr] <= (state_q != B_CLEAR);
		end
		rd_valid_q <= vmem[pos_q];
	end

	// Key memory
	always_ff @(posedge clk) begin
		if (do_ins) begin
			kmem[pos_q] <= key_q;
		end
		rd_key_q <= kmem[pos_q];
	end

	// Probe sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			pos_q       <= '0;
			inc_q       <= '0;
			probe_q     <= '0;
			act_q       <= 1'b0;
			key_q       <= '0;
			out_valid_q <= 1'b0;
			slot_q      <= '0;
			present_q   <= 1'b0;
			stored_q    <= 1'b0;
			full_q      <= 1'b0;
		end else begin
			// Raise a new result or drop the one taken
			if ((state_q == B_CHECK) && done && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CAPACITY - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (!empty) begin
						act_q   <= pop_data[EW-1];
						key_q   <= pop_data[AW +: KEY_BITS];
						pos_q   <= pop_data[AW-1:0];
						probe_q <= '0;
						inc_q   <= (n == NW'(1)) ? NW'(0) : NW'(1);
						state_q <= B_READ;
					end
				end
				B_READ: begin
					state_q <= B_CHECK;
				end
				B_CHECK: begin
					if (!done) begin
						pos_q   <= pos_nxt[AW-1:0];
						inc_q   <= inc_nxt;
						probe_q <= probe_q + NW'(1);
						state_q <= B_READ;
					end else if (out_free) begin
						if (!rd_valid_q || is_match) begin
							slot_q    <= qpht_pkg::SLOT_BITS'(pos_q);
							present_q <= is_match;
							stored_q  <= do_ins;
							full_q    <= 1'b0;
						end else begin
							slot_q    <= '0;
							present_q <= 1'b0;
							stored_q  <= 1'b0;
							full_q    <= 1'b1;
						end
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

### hdl/quadratic_probe_hash_table.sv
// Channel  Valid      Stall      Payload
// input    in_valid   in_stall   action, key
// output   out_valid  out_stall  slot, present, stored, table_full
// config   cfg_we     -          cfg_data (table_size)
//
// Front end: accepts a new transaction only after handing the last one to the
// queue, paced by the 4-bit-per-cycle remainder unit. Probe engine: each probe
// is a registered memory read and then a check, after a pick-up from the queue;
// the two overlap via a 2-entry queue. After reset a clearing pass empties the
// table while in_stall is held high. A stalled result holds the probe engine.
module quadratic_probe_hash_table #(
	parameter int CAPACITY = 1024,
	parameter int KEY_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [qpht_pkg::TS_BITS-1:0]   cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           action,
	input  logic [qpht_pkg::KEY_IN_BITS-1:0] key,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [qpht_pkg::SLOT_BITS-1:0] slot,
	output logic                           present,
	output logic                           stored,
	output logic                           table_full
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int NW = AW + 1;
	localparam int EW = 1 + KEY_BITS + AW;

	logic [qpht_pkg::TS_BITS-1:0] ts_q;
	logic [NW-1:0]                n;
	logic                         push;
	logic [EW-1:0]                push_data;
	logic                         full;
	logic                         pop;
	logic [EW-1:0]                pop_data;
	logic                         empty;
	qpht_pkg::back_status_t       status;

	// Hold table size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q <= qpht_pkg::TS_BITS'(1021);
		end else if (cfg_we) begin
			ts_q <= cfg_data;
		end
	end

	// Clamp slot count to 1..CAPACITY
	always_comb begin
		priority if (ts_q == '0) begin
			n = NW'(1);
		end else if (32'(ts_q) > 32'(CAPACITY)) begin
			n = NW'(CAPACITY);
		end else begin
			n = NW'(ts_q);
		end
	end

	qpht_front #(
		.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .AW(AW), .NW(NW), .EW(EW)
	) u_front (
		.clk(clk), .arst_n(arst_n), .status(status), .n(n),
		.in_valid(in_valid), .in_stall(in_stall), .action(action), .key(key),
		.push(push), .push_data(push_data), .full(full)
	);

	qpht_fifo #(.W(EW)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.full(full), .pop(pop), .pop_data(pop_data), .empty(empty)
	);

	qpht_back #(
		.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .AW(AW), .NW(NW), .EW(EW)
	) u_back (
		.clk(clk), .arst_n(arst_n), .status(status), .n(n),
		.empty(empty), .pop_data(pop_data), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall), .slot(slot),
		.present(present), .stored(stored), .table_full(table_full)
	);

endmodule
